// ===== src/pvp_pkg.sv =====
// Shared types and constants for the perspective vertex projection block.
package pvp_pkg;

  localparam int CfgIndexW = 4;
  localparam int ViewW     = 42;
  localparam int NumW      = 58;
  localparam int DivW      = 41;
  localparam int MagW      = 18;
  localparam int DivLat    = 18;

  localparam logic [CfgIndexW-1:0] REG_CAMERA_POS_X  = 4'd0;
  localparam logic [CfgIndexW-1:0] REG_CAMERA_POS_Y  = 4'd1;
  localparam logic [CfgIndexW-1:0] REG_CAMERA_POS_Z  = 4'd2;
  localparam logic [CfgIndexW-1:0] REG_PITCH_SIN_COS = 4'd3;
  localparam logic [CfgIndexW-1:0] REG_YAW_SIN_COS   = 4'd4;
  localparam logic [CfgIndexW-1:0] REG_ROLL_SIN_COS  = 4'd5;
  localparam logic [CfgIndexW-1:0] REG_FOCAL_SCALE   = 4'd6;
  localparam logic [CfgIndexW-1:0] REG_SCREEN_ORIGIN = 4'd7;

  localparam logic [1:0] STATUS_VISIBLE  = 2'd0;
  localparam logic [1:0] STATUS_BEHIND   = 2'd1;
  localparam logic [1:0] STATUS_ON_PLANE = 2'd2;

  localparam logic [MagW-1:0] MAG_SAT = 18'd131072;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
  } vertex_t;

  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic [1:0]         status;
  } result_t;

  typedef struct packed {
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
    logic [31:0]        pitch;
    logic [31:0]        yaw;
    logic [31:0]        roll;
  } cam_t;

  typedef struct packed {
    logic signed [ViewW-1:0] dx;
    logic signed [ViewW-1:0] dy;
    logic signed [ViewW-1:0] dz;
  } view_t;

  typedef struct packed {
    logic [1:0] status;
    logic       neg_x;
    logic       neg_y;
  } side_t;

endpackage

// ===== src/pvp_front.sv =====
// Front pipeline: camera translation and the three Euler rotations.
module pvp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  pvp_pkg::vertex_t vertex,
  input  pvp_pkg::cam_t   cam,
  output logic            out_valid,
  output pvp_pkg::view_t  view
);

  logic signed [15:0] sx, cx, sy, cy, sz, cz;
  assign sx = cam.pitch[31:16];
  assign cx = cam.pitch[15:0];
  assign sy = cam.yaw[31:16];
  assign cy = cam.yaw[15:0];
  assign sz = cam.roll[31:16];
  assign cz = cam.roll[15:0];

  logic [6:0] v;
  logic signed [32:0] x0, y0, z0, z1, z2;
  logic signed [48:0] m_szy, m_czx, m_czy, m_szx;
  logic signed [35:0] a2, b2, b3, b4;
  logic signed [51:0] m_cya, m_syz, m_cyz, m_sya;
  logic signed [38:0] dx4, c4, dx5, dx6;
  logic signed [54:0] m_sxc, m_cxb, m_cxc, m_sxb;
  logic signed [41:0] dy6, dz6;

  logic signed [49:0] sum_a, sum_b;
  logic signed [52:0] sum_dx, sum_c;
  logic signed [55:0] sum_dy, sum_dz;

  always_comb begin
    sum_a  = 50'(m_szy) + 50'(m_czx);
    sum_b  = 50'(m_czy) - 50'(m_szx);
    sum_dx = 53'(m_cya) - 53'(m_syz);
    sum_c  = 53'(m_cyz) + 53'(m_sya);
    sum_dy = 56'(m_sxc) + 56'(m_cxb);
    sum_dz = 56'(m_cxc) - 56'(m_sxb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    x0    <= 33'(vertex.vertex_x) - 33'(cam.cam_x);
    y0    <= 33'(vertex.vertex_y) - 33'(cam.cam_y);
    z0    <= 33'(vertex.vertex_z) - 33'(cam.cam_z);
    m_szy <= sz * y0;
    m_czx <= cz * x0;
    m_czy <= cz * y0;
    m_szx <= sz * x0;
    z1    <= z0;
    a2    <= 36'(sum_a >>> 14);
    b2    <= 36'(sum_b >>> 14);
    z2    <= z1;
    m_cya <= cy * a2;
    m_syz <= sy * z2;
    m_cyz <= cy * z2;
    m_sya <= sy * a2;
    b3    <= b2;
    dx4   <= 39'(sum_dx >>> 14);
    c4    <= 39'(sum_c >>> 14);
    b4    <= b3;
    m_sxc <= sx * c4;
    m_cxb <= cx * b4;
    m_cxc <= cx * c4;
    m_sxb <= sx * b4;
    dx5   <= dx4;
    dy6   <= 42'(sum_dy >>> 14);
    dz6   <= 42'(sum_dz >>> 14);
    dx6   <= dx5;
  end

  assign out_valid = v[6];
  assign view.dx   = 42'(dx6);
  assign view.dy   = dy6;
  assign view.dz   = dz6;

endmodule

// ===== src/pvp_queue.sv =====
// Two-entry queue between the rotation front and the projection back.
module pvp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pvp_pkg::view_t push_data,
  input  logic           pop,
  output logic           not_empty,
  output logic           full,
  output pvp_pkg::view_t pop_data
);

  pvp_pkg::view_t mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  logic do_push, do_pop;
  assign do_push = push && !full;
  assign do_pop  = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign pop_data  = mem[rd_ptr];

endmodule

// ===== src/pvp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
module pvp_div (
  input  logic                      clk,
  input  logic [pvp_pkg::NumW-1:0]  num,
  input  logic [pvp_pkg::DivW-1:0]  den,
  output logic [pvp_pkg::MagW-1:0]  quo
);

  localparam int QB = pvp_pkg::MagW - 1;

  logic [pvp_pkg::DivW-1:0] rem_q [QB+1];
  logic [pvp_pkg::DivW-1:0] den_q [QB+1];
  logic [QB-1:0]            low_q [QB+1];
  logic [QB-1:0]            q_q   [QB+1];
  logic                     ovf_q [QB+1];

  // A quotient of 2^17 or more saturates, so the top remainder is checked first.
  always_ff @(posedge clk) begin
    rem_q[0] <= num[pvp_pkg::NumW-1:QB];
    den_q[0] <= den;
    low_q[0] <= num[QB-1:0];
    q_q[0]   <= '0;
    ovf_q[0] <= (num[pvp_pkg::NumW-1:QB] >= den);
  end

  for (genvar j = 1; j <= QB; j++) begin : g_stage
    logic [pvp_pkg::DivW:0] trial;
    logic                   ge;
    assign trial = {rem_q[j-1], low_q[j-1][QB-1]};
    assign ge    = (trial >= {1'b0, den_q[j-1]});
    always_ff @(posedge clk) begin
      rem_q[j] <= ge ? pvp_pkg::DivW'(trial - {1'b0, den_q[j-1]})
                     : trial[pvp_pkg::DivW-1:0];
      den_q[j] <= den_q[j-1];
      low_q[j] <= {low_q[j-1][QB-2:0], 1'b0};
      q_q[j]   <= {q_q[j-1][QB-2:0], ge};
      ovf_q[j] <= ovf_q[j-1];
    end
  end

  assign quo = ovf_q[QB] ? pvp_pkg::MAG_SAT : {1'b0, q_q[QB]};

endmodule

// ===== src/pvp_back.sv =====
// Back pipeline: depth classification, focal scaling, depth divide and saturation.
module pvp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  pvp_pkg::view_t   view,
  input  logic [31:0]      focal,
  input  logic [31:0]      origin,
  output logic             out_valid,
  output pvp_pkg::result_t result
);

  localparam int VW = pvp_pkg::ViewW;

  logic [2:0] v;
  pvp_pkg::side_t side0, side1, side2;
  logic [VW-1:0]            mag_x, mag_y;
  logic [pvp_pkg::DivW-1:0] dz0, dz1, dz2;
  logic [52:0]              plx, phx, ply, phy;
  logic [pvp_pkg::NumW-1:0] nx, ny;
  logic [1:0]               status_in;

  always_comb begin
    if (view.dz < 0) begin
      status_in = pvp_pkg::STATUS_BEHIND;
    end else if (view.dz == '0) begin
      status_in = pvp_pkg::STATUS_ON_PLANE;
    end else begin
      status_in = pvp_pkg::STATUS_VISIBLE;
    end
  end

  always_ff @(posedge clk) begin
    side0.status <= status_in;
    side0.neg_x  <= view.dx[VW-1];
    side0.neg_y  <= view.dy[VW-1];
    mag_x <= view.dx[VW-1] ? VW'(-view.dx) : VW'(view.dx);
    mag_y <= view.dy[VW-1] ? VW'(-view.dy) : VW'(view.dy);
    dz0   <= view.dz[pvp_pkg::DivW-1:0];
    plx   <= mag_x[20:0] * focal;
    phx   <= mag_x[41:21] * focal;
    ply   <= mag_y[20:0] * focal;
    phy   <= mag_y[41:21] * focal;
    side1 <= side0;
    dz1   <= dz0;
    nx    <= pvp_pkg::NumW'((75'(plx) + (75'(phx) << 21)) >> 16);
    ny    <= pvp_pkg::NumW'((75'(ply) + (75'(phy) << 21)) >> 16);
    side2 <= side1;
    dz2   <= dz1;
  end

  logic [pvp_pkg::MagW-1:0] qx, qy;

  pvp_div u_div_x (.clk(clk), .num(nx), .den(dz2), .quo(qx));
  pvp_div u_div_y (.clk(clk), .num(ny), .den(dz2), .quo(qy));

  // Sideband travels beside the dividers with matching latency.
  pvp_pkg::side_t side_d [pvp_pkg::DivLat];
  logic [pvp_pkg::DivLat-1:0] v_d;

  always_ff @(posedge clk) begin
    side_d[0] <= side2;
    for (int i = 1; i < pvp_pkg::DivLat; i++) begin
      side_d[i] <= side_d[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      v_d       <= '0;
      out_valid <= 1'b0;
    end else begin
      v         <= {v[1:0], in_valid};
      v_d       <= {v_d[pvp_pkg::DivLat-2:0], v[2]};
      out_valid <= v_d[pvp_pkg::DivLat-1];
    end
  end

  function automatic logic signed [15:0] place(input logic [pvp_pkg::MagW-1:0] mag,
                                               input logic neg,
                                               input logic signed [15:0] org);
    logic signed [19:0] p;
    p = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    p = p + 20'(org);
    if (p > 20'sd32767) begin
      return 16'sh7fff;
    end else if (p < -20'sd32768) begin
      return 16'sh8000;
    end
    return p[15:0];
  endfunction

  pvp_pkg::side_t side_o;
  assign side_o = side_d[pvp_pkg::DivLat-1];

  always_ff @(posedge clk) begin
    result.status <= side_o.status;
    if (side_o.status == pvp_pkg::STATUS_VISIBLE) begin
      result.screen_x <= place(qx, side_o.neg_x, origin[31:16]);
      result.screen_y <= place(qy, side_o.neg_y, origin[15:0]);
    end else begin
      result.screen_x <= '0;
      result.screen_y <= '0;
    end
  end

endmodule

// ===== src/perspective_vertex_projection.sv =====
// Top level of the perspective vertex projection block with its register file.
//
// One vertex is accepted in every cycle in which start is high and busy is low; busy
// only rises if the internal queue fills, which it does not in steady streaming, so a
// vertex can be issued in every clock. Each result passes through a seven-stage rotation
// pipeline, a queue slot, three scaling stages, an 18-stage bit-per-cycle depth divider
// and the output register. The result is shown for one cycle with result_valid high and
// cannot be held off. Registers are written through the cfg channel, which is always
// ready; write them only while no vertex is in flight.
module perspective_vertex_projection (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  pvp_pkg::vertex_t                vertex,
  output logic                            result_valid,
  output pvp_pkg::result_t                result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pvp_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data
);

  pvp_pkg::cam_t cam;
  logic [31:0]   focal_scale, screen_origin;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam.cam_x     <= '0;
      cam.cam_y     <= '0;
      cam.cam_z     <= '0;
      cam.pitch     <= 32'd16384;
      cam.yaw       <= 32'd16384;
      cam.roll      <= 32'd16384;
      focal_scale   <= 32'd6553600;
      screen_origin <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pvp_pkg::REG_CAMERA_POS_X:  cam.cam_x     <= cfg_data;
        pvp_pkg::REG_CAMERA_POS_Y:  cam.cam_y     <= cfg_data;
        pvp_pkg::REG_CAMERA_POS_Z:  cam.cam_z     <= cfg_data;
        pvp_pkg::REG_PITCH_SIN_COS: cam.pitch     <= cfg_data;
        pvp_pkg::REG_YAW_SIN_COS:   cam.yaw       <= cfg_data;
        pvp_pkg::REG_ROLL_SIN_COS:  cam.roll      <= cfg_data;
        pvp_pkg::REG_FOCAL_SCALE:   focal_scale   <= cfg_data;
        pvp_pkg::REG_SCREEN_ORIGIN: screen_origin <= cfg_data;
        default: ;
      endcase
    end
  end

  logic           front_valid, q_not_empty, q_full;
  pvp_pkg::view_t front_view, q_view;

  pvp_front u_front (
    .clk(clk), .rst(rst), .in_valid(start && !busy), .vertex(vertex), .cam(cam),
    .out_valid(front_valid), .view(front_view)
  );

  pvp_queue u_queue (
    .clk(clk), .rst(rst), .push(front_valid), .push_data(front_view),
    .pop(1'b1), .not_empty(q_not_empty), .full(q_full), .pop_data(q_view)
  );

  pvp_back u_back (
    .clk(clk), .rst(rst), .in_valid(q_not_empty), .view(q_view),
    .focal(focal_scale), .origin(screen_origin),
    .out_valid(result_valid), .result(result)
  );

  assign busy = q_full;

endmodule
